// ===== hdl/signed_golomb_decoder_core_macros.svh =====
// Assertion macros for the signed Golomb decoder.
// Each expects clk and arst_n in the scope of use.
`ifndef SIGNED_GOLOMB_DECODER_CORE_MACROS_SVH
`define SIGNED_GOLOMB_DECODER_CORE_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define SGD_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("sgd assertion failed: invariant");

// Same-cycle implication.
`define SGD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sgd assertion failed: implication");

// Next-cycle implication.
`define SGD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sgd assertion failed: next-cycle implication");

`endif

// ===== hdl/sgd_pkg.sv =====
// Package for the signed Golomb decoder: parse phases, widths, defaults.
// No dependencies; used by the result interface, parser, value unit and top level.
`timescale 1ns / 1ps
`default_nettype none
package sgd_pkg;

	localparam int DIV_REG_W         = 16;
	localparam int VALUE_W           = 33;
	localparam int DIVISOR_BITS_DFLT = 16;
	localparam int QUOTIENT_BITS_DFLT = 16;
	localparam int OUT_DEPTH         = 4;
	localparam logic [DIV_REG_W-1:0] DIVISOR_RST = 16'd4;

	typedef enum logic [1:0] {
		PH_SIGN,
		PH_UNARY,
		PH_REM,
		PH_EXTRA
	} sgd_phase_t;

endpackage
`default_nettype wire

// ===== hdl/sgd_bit_if.sv =====
// Valid/ready channel carrying one coded bit per request.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface sgd_bit_if;
	logic valid;
	logic ready;
	logic code_bit;

	modport source (output valid, output code_bit, input ready);
	modport sink (input valid, input code_bit, output ready);
endinterface
`default_nettype wire

// ===== hdl/sgd_result_if.sv =====
// Valid/ready channel carrying one decoded value per request.
// Depends on sgd_pkg for the value width.
`timescale 1ns / 1ps
`default_nettype none
interface sgd_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [sgd_pkg::VALUE_W-1:0]  value;
	logic                                overflow;

	modport source (output valid, output value, output overflow, input ready);
	modport sink (input valid, input value, input overflow, output ready);
endinterface
`default_nettype wire

// ===== hdl/sgd_parser.sv =====
// Codeword parser: sign, unary quotient and remainder state machine.
// Hands a completed codeword to the value unit; depends on sgd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sgd_parser #(
	parameter int MW = 16,
	parameter int QB = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire logic                 code_bit,
	input  wire logic [MW-1:0]        divisor,
	output logic                      emit,
	output logic                      emit_v_s1,
	output logic                      sign_s1,
	output logic                      ovf_s1,
	output logic [QB-1:0]             q_s1,
	output logic [MW-1:0]             m_s1,
	output logic signed [MW:0]        r_s1
);
	import sgd_pkg::*;

	localparam int BL_W = $clog2(MW);

	sgd_phase_t       phase_q, phase_d;
	logic             sign_q, sign_d;
	logic             ovf_q, ovf_d;
	logic [QB-1:0]    q_q, q_d;
	logic [MW-1:0]    acc_q, acc_d;
	logic [BL_W-1:0]  bl_q, bl_d;

	logic [MW-1:0]    m_eff;
	logic [BL_W-1:0]  fl;
	logic             pow2;
	logic [MW:0]      pw;
	logic [MW:0]      off;
	logic [MW-1:0]    acc_n;
	logic [MW:0]      fr;
	logic             rem_fits;
	logic [MW:0]      r_em;

	// zero divisor behaves as one
	assign m_eff = (divisor == '0) ? MW'(1) : divisor;
	assign pow2  = ((m_eff & (m_eff - MW'(1))) == '0);

	always_comb begin
		fl = '0;
		for (int i = 1; i < MW; i++) begin
			if (m_eff[i]) begin
				fl = BL_W'(i);
			end
		end
	end

	// offset of truncated binary: 2^(floor_log2+1) - m
	assign pw       = {1'b1, {MW{1'b0}}} >> (BL_W'(MW - 1) - fl);
	assign off      = pw - {1'b0, m_eff};
	assign acc_n    = {acc_q[MW-2:0], code_bit};
	assign fr       = {acc_q, code_bit};
	assign rem_fits = pow2 || ({1'b0, acc_n} < off);

	// next state
	always_comb begin
		phase_d = phase_q;
		sign_d  = sign_q;
		ovf_d   = ovf_q;
		q_d     = q_q;
		acc_d   = acc_q;
		bl_d    = bl_q;
		if (accept) begin
			case (phase_q)
				PH_SIGN: begin
					sign_d  = code_bit;
					ovf_d   = 1'b0;
					q_d     = '0;
					acc_d   = '0;
					bl_d    = '0;
					phase_d = PH_UNARY;
				end
				PH_UNARY: begin
					if (!code_bit) begin
						if (q_q == '1) begin
							ovf_d = 1'b1;
						end else begin
							q_d = q_q + QB'(1);
						end
					end else begin
						acc_d   = '0;
						bl_d    = fl;
						phase_d = (fl == '0) ? PH_SIGN : PH_REM;
					end
				end
				PH_REM: begin
					acc_d = acc_n;
					bl_d  = bl_q - BL_W'(1);
					if (bl_q == BL_W'(1)) begin
						phase_d = rem_fits ? PH_SIGN : PH_EXTRA;
					end
				end
				PH_EXTRA: begin
					phase_d = PH_SIGN;
				end
				default: begin
					phase_d = PH_SIGN;
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		emit = 1'b0;
		r_em = '0;
		if (accept) begin
			case (phase_q)
				PH_UNARY: begin
					emit = code_bit && (fl == '0);
				end
				PH_REM: begin
					emit = (bl_q == BL_W'(1)) && rem_fits;
					r_em = {1'b0, acc_n};
				end
				PH_EXTRA: begin
					emit = 1'b1;
					r_em = fr - off;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SIGN;
			sign_q    <= 1'b0;
			ovf_q     <= 1'b0;
			q_q       <= '0;
			acc_q     <= '0;
			bl_q      <= '0;
			emit_v_s1 <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			sign_q    <= sign_d;
			ovf_q     <= ovf_d;
			q_q       <= q_d;
			acc_q     <= acc_d;
			bl_q      <= bl_d;
			emit_v_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sign_s1 <= sign_q;
			ovf_s1  <= ovf_q;
			q_s1    <= q_q;
			m_s1    <= m_eff;
			r_s1    <= r_em;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/sgd_value_unit.sv =====
// Value unit: quotient times divisor, then remainder add and sign.
// Registers the product behind the parser, then adds and signs; depends on sgd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sgd_value_unit #(
	parameter int MW = 16,
	parameter int QB = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          v_s1,
	input  wire logic                          sign_s1,
	input  wire logic                          ovf_s1,
	input  wire logic [QB-1:0]                 q_s1,
	input  wire logic [MW-1:0]                 m_s1,
	input  wire logic signed [MW:0]            r_s1,
	output logic                               push,
	output logic [sgd_pkg::VALUE_W:0]          push_data
);
	import sgd_pkg::*;

	localparam int PW = QB + MW;

	logic                v_s2;
	logic                sign_s2;
	logic                ovf_s2;
	logic [PW-1:0]       prod_s2;
	logic signed [MW:0]  r_s2;

	logic [VALUE_W+PW-1:0] prod_ext;
	logic [VALUE_W-1:0]    mag;
	logic [VALUE_W-1:0]    val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= PW'(q_s1) * PW'(m_s1);
			r_s2    <= r_s1;
			sign_s2 <= sign_s1;
			ovf_s2  <= ovf_s1;
		end
	end

	// everything wraps modulo 2^VALUE_W; the remainder may be negative
	assign prod_ext  = {{VALUE_W{1'b0}}, prod_s2};
	assign mag       = prod_ext[VALUE_W-1:0]
	                 + {{(VALUE_W - MW - 1){r_s2[MW]}}, r_s2};
	assign val       = sign_s2 ? (VALUE_W'(0) - mag) : mag;
	assign push      = v_s2;
	assign push_data = {val, ovf_s2};

endmodule
`default_nettype wire

// ===== hdl/sgd_out_fifo.sv =====
// Small register FIFO holding finished results until the sink takes them.
// Generic width and depth; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module sgd_out_fifo #(
	parameter int W     = 34,
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [W-1:0]  push_data,
	input  wire logic          pop,
	output logic               valid,
	output logic [W-1:0]       data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign valid  = (cnt_q != '0);
	assign data   = mem_q[rd_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/signed_golomb_decoder_core.sv =====
// Signed Golomb decoder: one coded bit in per request, one signed value out
// per codeword (sign bit, unary quotient, plain or truncated-binary remainder).
//
// Channels: bit_in takes a code bit when valid and ready are both high;
// result gives value (33-bit two's complement) and overflow the same way.
// divisor_we writes divisor_wdata into the divisor register (reset value 4);
// write it between codewords.
// Throughput: one bit per cycle while bit_in.ready is high. Each bit
// updates the registered parser state; the value path behind it (multiplier
// stage, then add and negate) is pipelined, so bits keep flowing.
// A result passes the parser's s1 registers, the value unit's s2 registers and
// the output queue before it is offered on result.
// Up to four results may wait in the output queue. When the sink stalls and
// four results are pending, bit_in.ready drops until one is taken.
// Reset (arst_n low) returns the parser to the sign bit, empties the queue
// and sets the divisor to 4.
`timescale 1ns / 1ps
`default_nettype none
`include "signed_golomb_decoder_core_macros.svh"
module signed_golomb_decoder_core #(
	parameter int DIVISOR_BITS  = sgd_pkg::DIVISOR_BITS_DFLT,
	parameter int QUOTIENT_BITS = sgd_pkg::QUOTIENT_BITS_DFLT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            divisor_we,
	input  wire logic [sgd_pkg::DIV_REG_W-1:0]   divisor_wdata,
	sgd_bit_if.sink                              bit_in,
	sgd_result_if.source                         result
);
	import sgd_pkg::*;

	localparam int MW    = (DIVISOR_BITS < DIV_REG_W) ? DIVISOR_BITS : DIV_REG_W;
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	logic [DIV_REG_W-1:0] divisor_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 accept;
	logic                 emit;
	logic                 res_fire;

	logic                 v_s1;
	logic                 sign_s1;
	logic                 ovf_s1;
	logic [QUOTIENT_BITS-1:0] q_s1;
	logic [MW-1:0]        m_s1;
	logic signed [MW:0]   r_s1;

	logic                 push;
	logic [VALUE_W:0]     push_data;
	logic                 q_valid;
	logic [VALUE_W:0]     q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= DIVISOR_RST;
		end else if (divisor_we) begin
			divisor_q <= divisor_wdata;
		end
	end

	// pending results, from the emitting bit until the sink takes them
	assign bit_in.ready = (cnt_q < CNT_W'(OUT_DEPTH));
	assign accept       = bit_in.valid && bit_in.ready;
	assign res_fire     = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({emit, res_fire})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	sgd_parser #(
		.MW (MW),
		.QB (QUOTIENT_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.code_bit  (bit_in.code_bit),
		.divisor   (divisor_q[MW-1:0]),
		.emit      (emit),
		.emit_v_s1 (v_s1),
		.sign_s1   (sign_s1),
		.ovf_s1    (ovf_s1),
		.q_s1      (q_s1),
		.m_s1      (m_s1),
		.r_s1      (r_s1)
	);

	sgd_value_unit #(
		.MW (MW),
		.QB (QUOTIENT_BITS)
	) u_value (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_s1      (v_s1),
		.sign_s1   (sign_s1),
		.ovf_s1    (ovf_s1),
		.q_s1      (q_s1),
		.m_s1      (m_s1),
		.r_s1      (r_s1),
		.push      (push),
		.push_data (push_data)
	);

	sgd_out_fifo #(
		.W     (VALUE_W + 1),
		.DEPTH (OUT_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (result.ready),
		.valid     (q_valid),
		.data      (q_data)
	);

	assign result.valid    = q_valid;
	assign result.value    = q_data[VALUE_W:1];
	assign result.overflow = q_data[0];

	`SGD_ASSERT_ALWAYS(a_pending_bound, cnt_q <= CNT_W'(OUT_DEPTH))
	`SGD_ASSERT_IMPL(a_emit_needs_accept, emit, accept)
	`SGD_ASSERT_IMPL(a_result_is_pending, result.valid, cnt_q != '0)
	`SGD_ASSERT_NEXT(a_emit_counted, emit && !res_fire, cnt_q != '0)

endmodule
`default_nettype wire
